// ===== design/bssc_pkg.sv =====
// Shared types, widths, register map and reset values of the stereo compressor.
package bssc_pkg;

   // Fixed-point formats
   localparam int COEF_FRAC_BITS = 16;
   localparam int GAIN_W         = COEF_FRAC_BITS + 1;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << COEF_FRAC_BITS);

   localparam int PHASE_FRAC = 32;
   localparam int PHASE_W    = PHASE_FRAC + 1;
   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC;

   localparam int POINT_W     = 32;
   localparam int CURVE_FRAC  = 24;
   localparam int CURVE_W     = POINT_W + 3;
   localparam int CURVE_SHIFT = CURVE_FRAC - COEF_FRAC_BITS;

   // Register widths
   localparam int THR_W  = 19;
   localparam int INV_W  = 17;
   localparam int DET_W  = 17;
   localparam int RATE_W = 29;
   localparam int TRIM_W = 16;
   localparam int MIX_W  = 17;

   // Second operand of the shared multiplier covers the widest rate
   localparam int MUL_B_W = RATE_W;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_THRESHOLD,
      REG_INVERSE_THRESHOLD,
      REG_DETECT_LIMIT,
      REG_SEGMENT_RATE,
      REG_RELEASE_RATE,
      REG_PHASE_TRIM,
      REG_DRY_MIX
   } reg_index_type;

   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [INV_W-1:0]  inverse_threshold;
      logic [DET_W-1:0]  detect_limit;
      logic [RATE_W-1:0] segment_rate;
      logic [RATE_W-1:0] release_rate;
      logic [TRIM_W-1:0] phase_trim;
      logic [MIX_W-1:0]  dry_mix;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      threshold:         THR_W'(132547),
      inverse_threshold: INV_W'(32403),
      detect_limit:      DET_W'(57600),
      segment_rate:      RATE_W'(8388608),
      release_rate:      RATE_W'(8388608),
      phase_trim:        TRIM_W'(65408),
      dry_mix:           MIX_W'(21349)
   };

   // Sequencer control
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CALC  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef enum logic [4:0] {
      SQ_L_GAIN,
      SQ_L_INV,
      SQ_PHASE,
      SQ_R_GAIN,
      SQ_R_INV,
      SQ_WA,
      SQ_WB,
      SQ_WC,
      SQ_LIMIT,
      SQ_HOLD,
      SQ_LEVEL,
      SQ_SEGMENT,
      SQ_OLDEST,
      SQ_MIDDLE,
      SQ_NEWEST,
      SQ_GAIN,
      SQ_WET,
      SQ_DRYCOEF,
      SQ_L_DRY,
      SQ_L_WET,
      SQ_L_THR,
      SQ_R_DRY,
      SQ_R_WET,
      SQ_R_THR
   } step_type;

endpackage

// ===== design/bssc_if.sv =====
// Stream interfaces for sample beats in and compressed beats out.
interface bssc_req_if #(
   parameter int SAMPLE_BITS = 24
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_left;
   logic signed [SAMPLE_BITS-1:0] sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface bssc_rsp_if #(
   parameter int SAMPLE_BITS = 24
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== design/bssc_mul.sv =====
// Shared unsigned multiplier with a registered product.
module bssc_mul #(
   parameter int A_W = 33,
   parameter int B_W = 29
) (
   input  logic               clock,
   input  logic               mul_en,
   input  logic [A_W-1:0]     mul_a,
   input  logic [B_W-1:0]     mul_b,
   output logic [A_W+B_W-1:0] prod_ff
);

   logic [A_W+B_W-1:0] prod_in;

   // Form the full-width product
   assign prod_in = (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);

   // Hold the product until the next issued operation
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== design/bssc_csr.sv =====
// APB-style register file for the compressor settings.
module bssc_csr
   import bssc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_THRESHOLD:         cfg_in.threshold         = csr_pwdata[THR_W-1:0];
            REG_INVERSE_THRESHOLD: cfg_in.inverse_threshold = csr_pwdata[INV_W-1:0];
            REG_DETECT_LIMIT:      cfg_in.detect_limit      = csr_pwdata[DET_W-1:0];
            REG_SEGMENT_RATE:      cfg_in.segment_rate      = csr_pwdata[RATE_W-1:0];
            REG_RELEASE_RATE:      cfg_in.release_rate      = csr_pwdata[RATE_W-1:0];
            REG_PHASE_TRIM:        cfg_in.phase_trim        = csr_pwdata[TRIM_W-1:0];
            REG_DRY_MIX:           cfg_in.dry_mix           = csr_pwdata[MIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_index)
         REG_THRESHOLD:         csr_prdata = CSR_DATA_W'(cfg_ff.threshold);
         REG_INVERSE_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.inverse_threshold);
         REG_DETECT_LIMIT:      csr_prdata = CSR_DATA_W'(cfg_ff.detect_limit);
         REG_SEGMENT_RATE:      csr_prdata = CSR_DATA_W'(cfg_ff.segment_rate);
         REG_RELEASE_RATE:      csr_prdata = CSR_DATA_W'(cfg_ff.release_rate);
         REG_PHASE_TRIM:        csr_prdata = CSR_DATA_W'(cfg_ff.phase_trim);
         REG_DRY_MIX:           csr_prdata = CSR_DATA_W'(cfg_ff.dry_mix);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/bssc_core.sv =====
// Step sequencer and datapath around the shared multiplier.
module bssc_core
   import bssc_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_left,
   input  logic signed [SAMPLE_BITS-1:0] in_right,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] out_left,
   output logic signed [SAMPLE_BITS-1:0] out_right
);

   localparam int SFRAC       = SAMPLE_BITS - 1;
   localparam int HELD_W      = SAMPLE_BITS + 1;
   localparam int MUL_A_W     = (HELD_W > PHASE_W) ? HELD_W : PHASE_W;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int LIM_SHL     = (SFRAC >= COEF_FRAC_BITS) ? SFRAC - COEF_FRAC_BITS : 0;
   localparam int LIM_SHR     = (SFRAC >= COEF_FRAC_BITS) ? 0 : COEF_FRAC_BITS - SFRAC;
   localparam int LIM_BASE_W  = DET_W + 1;
   localparam int CMP_W       = LIM_BASE_W + LIM_SHL + RATE_W;
   localparam int REL_SHIFT   = PHASE_FRAC - SFRAC;
   localparam int LEVEL_SHIFT = SFRAC + 8;
   localparam int LEVEL_W     = 23;
   localparam int WET_W       = SAMPLE_BITS + 3;
   localparam int ACC_W       = SAMPLE_BITS + 4;

   state_type                     state_ff, state_in;
   step_type                      step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] sl_ff, sl_in, sr_ff, sr_in;
   logic [SAMPLE_BITS-1:0]        ml_ff, ml_in, mr_ff, mr_in;
   logic [GAIN_W-1:0]             x_ff, x_in;
   logic [GAIN_W-1:0]             wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in;
   logic [GAIN_W-1:0]             gain_ff, gain_in;
   logic [GAIN_W-1:0]             wl_ff, wl_in, drycoef_ff, drycoef_in;
   logic [HELD_W-1:0]             held_ff, held_in;
   logic [POINT_W-1:0]            level_ff, level_in;
   logic [PHASE_W-1:0]            phase_ff, phase_in;
   logic                          wrap_ff, wrap_in;
   logic [POINT_W-1:0]            newest_ff, newest_in, middle_ff, middle_in;
   logic [POINT_W-1:0]            oldest_ff, oldest_in;
   logic [CURVE_W-1:0]            curve_ff, curve_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] left_work_ff, left_work_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;

   logic                          mul_en;
   logic [MUL_A_W-1:0]            mul_a;
   logic [MUL_B_W-1:0]            mul_b;
   logic [PROD_W-1:0]             mul_prod;

   logic [SAMPLE_BITS-1:0]        mag_l, mag_r;
   logic [SAMPLE_BITS-1:0]        prod_sample;
   logic [GAIN_W-1:0]             prod_coef;
   logic [POINT_W:0]              prod_point;
   logic [GAIN_W-1:0]             omx, dry, wetfac;
   logic [CMP_W-1:0]              lim_c, peak_c, ctrl_c, rel_c, held_c, decayed_c;
   logic [PHASE_W:0]              phase_sum;
   logic [POINT_W:0]              level_sum;
   logic [POINT_W-1:0]            level_sat;
   logic [CURVE_W-1:0]            curve_total;
   logic [ACC_W-1:0]              out_mag;
   logic                          finish_ok;

   // Saturate a sign and magnitude pair to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic             neg,
      input logic [ACC_W-1:0] mag
   );
      logic [ACC_W-1:0]              pos_max;
      logic signed [SAMPLE_BITS-1:0] res;
      pos_max = (ACC_W'(1) << SFRAC) - ACC_W'(1);
      if (!neg) begin
         res = (mag > pos_max) ? {1'b0, {SFRAC{1'b1}}} : SAMPLE_BITS'(mag);
      end else if (mag > pos_max + ACC_W'(1)) begin
         res = {1'b1, {SFRAC{1'b0}}};
      end else begin
         res = -(SAMPLE_BITS'(mag));
      end
      return res;
   endfunction

   bssc_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_prod)
   );

   // Common views of the product register
   assign prod_sample = mul_prod[COEF_FRAC_BITS +: SAMPLE_BITS];
   assign prod_coef   = mul_prod[COEF_FRAC_BITS +: GAIN_W];
   assign prod_point  = mul_prod[COEF_FRAC_BITS +: POINT_W+1];

   assign mag_l  = sl_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sl_ff) : SAMPLE_BITS'(sl_ff);
   assign mag_r  = sr_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sr_ff) : SAMPLE_BITS'(sr_ff);
   assign omx    = GAIN_ONE - x_ff;
   assign dry    = (cfg.dry_mix > GAIN_W'(GAIN_ONE)) ? GAIN_ONE : GAIN_W'(cfg.dry_mix);
   assign wetfac = GAIN_ONE - dry;

   // Peak hold: cap the louder channel, decay the held level, keep the larger
   assign lim_c     = (CMP_W'(mul_prod[COEF_FRAC_BITS +: LIM_BASE_W]) << LIM_SHL) >> LIM_SHR;
   assign peak_c    = (ml_ff > mr_ff) ? CMP_W'(ml_ff) : CMP_W'(mr_ff);
   assign ctrl_c    = (peak_c > lim_c) ? lim_c : peak_c;
   assign rel_c     = CMP_W'(cfg.release_rate >> REL_SHIFT);
   assign held_c    = CMP_W'(held_ff);
   assign decayed_c = (held_c > rel_c) ? held_c - rel_c : '0;

   // Segment phase and level sum
   assign phase_sum = (PHASE_W+1)'(phase_ff) + (PHASE_W+1)'(cfg.segment_rate);
   assign level_sum = (POINT_W+1)'(level_ff) + (POINT_W+1)'(mul_prod[LEVEL_SHIFT +: LEVEL_W]);
   assign level_sat = level_sum[POINT_W] ? '1 : level_sum[POINT_W-1:0];

   assign curve_total = curve_ff + CURVE_W'(prod_point);
   assign out_mag     = acc_ff + ACC_W'(mul_prod[COEF_FRAC_BITS +: WET_W]);
   assign finish_ok   = !rsp_valid_ff || out_ready;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = rsp_valid_ff;
   assign out_left  = rsp_left_ff;
   assign out_right = rsp_right_ff;

   // Select the multiplier operands for each step
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      if (state_ff == ST_CALC) begin
         unique case (step_ff)
            SQ_L_GAIN: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(mag_l); mul_b = MUL_B_W'(gain_ff);
            end
            SQ_L_INV, SQ_R_INV: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(prod_sample);
               mul_b  = MUL_B_W'(cfg.inverse_threshold);
            end
            SQ_PHASE: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(phase_ff); mul_b = MUL_B_W'(cfg.phase_trim);
            end
            SQ_R_GAIN: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(mag_r); mul_b = MUL_B_W'(gain_ff);
            end
            SQ_WA: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(omx); mul_b = MUL_B_W'(omx);
            end
            SQ_WB: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(omx); mul_b = MUL_B_W'(x_ff);
            end
            SQ_WC: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(x_ff); mul_b = MUL_B_W'(x_ff);
            end
            SQ_LIMIT: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(cfg.detect_limit); mul_b = MUL_B_W'(gain_ff);
            end
            SQ_LEVEL: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(held_ff); mul_b = MUL_B_W'(cfg.segment_rate);
            end
            SQ_OLDEST: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(oldest_ff); mul_b = MUL_B_W'(wa_ff);
            end
            SQ_MIDDLE: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(middle_ff); mul_b = MUL_B_W'(wb_ff);
            end
            SQ_NEWEST: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(newest_ff); mul_b = MUL_B_W'(wc_ff);
            end
            SQ_WET: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(gain_ff); mul_b = MUL_B_W'(wetfac);
            end
            SQ_DRYCOEF: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(dry);
               mul_b  = MUL_B_W'(GAIN_ONE - prod_coef);
            end
            SQ_L_DRY: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(mag_l); mul_b = MUL_B_W'(prod_coef);
            end
            SQ_L_WET: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(ml_ff); mul_b = MUL_B_W'(wl_ff);
            end
            SQ_L_THR, SQ_R_THR: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(prod_sample); mul_b = MUL_B_W'(cfg.threshold);
            end
            SQ_R_DRY: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(mag_r); mul_b = MUL_B_W'(drycoef_ff);
            end
            SQ_R_WET: begin
               mul_en = 1'b1; mul_a = MUL_A_W'(mr_ff); mul_b = MUL_B_W'(wl_ff);
            end
            default: ;
         endcase
      end
   end

   // Advance the sequencer and capture step results
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      ml_in        = ml_ff;
      mr_in        = mr_ff;
      x_in         = x_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      gain_in      = gain_ff;
      wl_in        = wl_ff;
      drycoef_in   = drycoef_ff;
      held_in      = held_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      wrap_in      = wrap_ff;
      newest_in    = newest_ff;
      middle_in    = middle_ff;
      oldest_in    = oldest_ff;
      curve_in     = curve_ff;
      acc_in       = acc_ff;
      left_work_in = left_work_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      // Drop the result once taken
      if (out_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               sl_in    = in_left;
               sr_in    = in_right;
               step_in  = SQ_L_GAIN;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            step_in = step_type'(step_ff + 5'd1);
            if (step_ff == SQ_R_THR) begin
               state_in = ST_DRAIN;
            end
            unique case (step_ff)
               SQ_L_GAIN: begin
                  wrap_in  = (phase_sum > (PHASE_W+1)'(PHASE_ONE));
                  phase_in = wrap_in ? '0 : phase_sum[PHASE_W-1:0];
               end
               SQ_PHASE:  ml_in = prod_sample;
               SQ_R_GAIN: begin
                  x_in = mul_prod[PHASE_FRAC +: GAIN_W];
                  if (x_in > GAIN_ONE) begin
                     x_in = GAIN_ONE;
                  end
               end
               SQ_WA:     mr_in = prod_sample;
               SQ_WB:     wa_in = prod_coef;
               SQ_WC:     wb_in = mul_prod[COEF_FRAC_BITS-1 +: GAIN_W];
               SQ_LIMIT:  wc_in = prod_coef;
               SQ_HOLD:   held_in = HELD_W'((ctrl_c > decayed_c) ? ctrl_c : decayed_c);
               SQ_SEGMENT: begin
                  if (wrap_ff) begin
                     oldest_in = middle_ff;
                     middle_in = newest_ff;
                     newest_in = level_sat;
                     level_in  = '0;
                  end else begin
                     level_in = level_sat;
                  end
               end
               SQ_MIDDLE: curve_in = CURVE_W'(middle_ff) + CURVE_W'(prod_point);
               SQ_NEWEST: curve_in = curve_total;
               SQ_GAIN: begin
                  if (curve_total >= (CURVE_W'(1) << CURVE_FRAC)) begin
                     gain_in = '0;
                  end else begin
                     gain_in = GAIN_ONE - GAIN_W'(curve_total >> CURVE_SHIFT);
                  end
               end
               SQ_DRYCOEF: wl_in = prod_coef;
               SQ_L_DRY:   drycoef_in = prod_coef;
               SQ_L_WET, SQ_R_WET: acc_in = ACC_W'(prod_sample);
               SQ_R_DRY:   left_work_in = saturate(sl_ff[SAMPLE_BITS-1], out_mag);
               default: ;
            endcase
         end
         ST_DRAIN: begin
            // Hold the finished pair until the output register frees up
            if (finish_ok) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_work_ff;
               rsp_right_in = saturate(sr_ff[SAMPLE_BITS-1], out_mag);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and compressor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SQ_L_GAIN;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= '0;
         held_ff      <= '0;
         level_ff     <= '0;
         phase_ff     <= PHASE_ONE;
         wrap_ff      <= 1'b0;
         newest_ff    <= '0;
         middle_ff    <= '0;
         oldest_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         held_ff      <= held_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         wrap_ff      <= wrap_in;
         newest_ff    <= newest_in;
         middle_ff    <= middle_in;
         oldest_ff    <= oldest_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      sl_ff        <= sl_in;
      sr_ff        <= sr_in;
      ml_ff        <= ml_in;
      mr_ff        <= mr_in;
      x_ff         <= x_in;
      wa_ff        <= wa_in;
      wb_ff        <= wb_in;
      wc_ff        <= wc_in;
      wl_ff        <= wl_in;
      drycoef_ff   <= drycoef_in;
      curve_ff     <= curve_in;
      acc_ff       <= acc_in;
      left_work_ff <= left_work_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> !in_ready)
      else $error("input beat accepted while an item is in flight");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE)
      else $error("gain above unity");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_ONE)
      else $error("segment phase above one");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && step_ff == SQ_R_THR) |=> (state_ff == ST_DRAIN))
      else $error("sequencer skipped the output step");

   a_drain_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && rsp_valid_ff && !out_ready) |=> (state_ff == ST_DRAIN))
      else $error("result overwritten while the output register is full");

endmodule

// ===== design/bezier_smoothed_stereo_compressor.sv =====
// Top level of the linked-gain stereo compressor with Bezier gain smoothing.
//
//   Port group   Direction  Beat contents
//   req          in         sample_left, sample_right (signed Q1.(SAMPLE_BITS-1))
//   rsp          out        out_left, out_right (signed, saturated)
//   csr_*        in/out     APB-style register writes and reads, 4-byte stride
//
// An item passes the accept cycle, 24 sequencer steps and one output step that can stall.
// Every product goes through the single registered multiplier, at most one per step.
// A new beat is taken only while the sequencer is idle; a result waiting in the
// output register does not block the next accept, only the output step of the next item.
// Synchronous reset restores the register defaults, zero gain and a full segment phase.
module bezier_smoothed_stereo_compressor
   import bssc_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   bssc_req_if.sink              req,
   bssc_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // Register file
   bssc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequenced datapath
   bssc_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_left   (req.sample_left),
      .in_right  (req.sample_right),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_left  (rsp.out_left),
      .out_right (rsp.out_right)
   );

endmodule
